// ----- src/arqtt_pkg.sv -----
// Shared types and constants for the ARQ retransmit timer table.
// Used by arqtt_front, arqtt_back and arq_retransmit_timer_table_unit.
`timescale 1ns / 1ps
`default_nettype none

package arqtt_pkg;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_TICK   = 2'd2,
    OP_RESEND = 2'd3
  } op_t;

  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_INFO = 1'b1;

  localparam logic [15:0] RETX_TIMEOUT_RST = 16'd100;

  // Classified command handed from the front to the back
  typedef struct packed {
    op_t         op;
    logic [15:0] delay;
    logic [3:0]  packet;
    logic        kind;
    logic [2:0]  info;
    logic        send_now;   // data add with zero delay
  } cmd_t;

  // One send result
  typedef struct packed {
    logic       send_kind;
    logic [3:0] send_packet;
    logic [2:0] send_info;
    logic       piggy_valid;
    logic [2:0] piggy_info;
    logic [3:0] piggy_packet;
  } res_t;

  typedef enum logic [1:0] {
    RET_STORE = 2'd0,
    RET_TICK  = 2'd1,
    RET_FIN   = 2'd2
  } ret_t;

endpackage

`default_nettype wire

// ----- src/arq_retransmit_timer_table_unit.sv -----
// Top level of the ARQ retransmit timer table: stream ports, configuration
// register and output register. Depends on arqtt_pkg, arqtt_front, arqtt_back.
`timescale 1ns / 1ps
`default_nettype none

// Retransmit/acknowledge timer table for a sliding-window link. Commands
// enter on the in_ stream (two-entry queue); sends leave on the out_ stream,
// out_tlast marking the final send of a command. The table engine visits one
// slot per clock while the output can take its sends: remove and tick walk
// every slot, and every data send (tick expiry, resend, or data add with zero
// delay) adds a scan of the table for the soonest info entry to piggyback;
// resend adds one more scan for the soonest data entry. The resend timeout
// is written on the cfg_ channel; the user must write it only while the
// block is idle, which the block itself does not enforce.
module arq_retransmit_timer_table_unit
  import arqtt_pkg::*;
#(
  parameter int TABLE_SLOTS = 16,
  parameter int TIME_BITS   = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // delay[15:0], seq_num[19:16], info_code[22:20]
  input  wire logic [2:0]  in_tuser,   // opcode[1:0], kind[2]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // send_packet[3:0], send_info[6:4], piggy_valid[7],
                                       // piggy_info[10:8], piggy_packet[14:11]
  output logic             out_tuser,  // send_kind
  output logic             out_tlast,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_data
);

  logic        cmd_valid, cmd_pop;
  cmd_t        cmd;
  logic        res_valid, res_last, res_ready;
  res_t        res;
  logic [15:0] dt_r;
  logic        ov_r, ov_nxt;
  res_t        ores_r;
  logic        olast_r;

  // Configuration register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dt_r <= RETX_TIMEOUT_RST;
    end else if (cfg_valid) begin
      dt_r <= cfg_data;
    end
  end

  arqtt_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_opcode (in_tuser[1:0]),
    .in_delay  (in_tdata[15:0]),
    .in_packet (in_tdata[19:16]),
    .in_kind   (in_tuser[2]),
    .in_info   (in_tdata[22:20]),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  arqtt_back #(
    .TABLE_SLOTS (TABLE_SLOTS),
    .TIME_BITS   (TIME_BITS)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd),
    .cmd_pop      (cmd_pop),
    .retx_timeout (dt_r),
    .res_valid    (res_valid),
    .res          (res),
    .res_last     (res_last),
    .res_ready    (res_ready)
  );

  // Output register
  assign res_ready = !ov_r || out_tready;
  always_comb begin
    ov_nxt = ov_r;
    if (res_valid) begin
      ov_nxt = 1'b1;
    end else if (out_tready) begin
      ov_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else begin
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      ores_r  <= res;
      olast_r <= res_last;
    end
  end

  assign out_tvalid = ov_r;
  assign out_tuser  = ores_r.send_kind;
  assign out_tlast  = olast_r;
  assign out_tdata  = {1'b0, ores_r.piggy_packet, ores_r.piggy_info, ores_r.piggy_valid,
                       ores_r.send_info, ores_r.send_packet};

endmodule

`default_nettype wire

// ----- src/arqtt_front.sv -----
// Command front end: accepts input transactions, classifies them and queues
// them in a two-entry queue for the back end. Depends on arqtt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module arqtt_front
  import arqtt_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_opcode,
  input  wire logic [15:0] in_delay,
  input  wire logic [3:0]  in_packet,
  input  wire logic        in_kind,
  input  wire logic [2:0]  in_info,
  output logic             cmd_valid,
  output cmd_t             cmd,
  input  wire logic        cmd_pop
);

  cmd_t       q_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;
  cmd_t       cmd_in;

  // Classify the incoming command
  always_comb begin
    cmd_in.op       = op_t'(in_opcode);
    cmd_in.delay    = in_delay;
    cmd_in.packet   = in_packet;
    cmd_in.kind     = in_kind;
    cmd_in.info     = in_info;
    cmd_in.send_now = (op_t'(in_opcode) == OP_ADD) && (in_kind == KIND_DATA) &&
                      (in_delay == 16'd0);
  end

  assign in_ready  = (cnt_r != 2'd2);
  assign push      = in_valid && in_ready;
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rp_r];

  // Queue pointers
  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = cmd_pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, cmd_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= cmd_in;
    end
  end

endmodule

`default_nettype wire

// ----- src/arqtt_back.sv -----
// Timer table back end: slot storage and the sequencer for add, remove, tick
// and resend, one slot per cycle unless a send stalls. Depends on arqtt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module arqtt_back
  import arqtt_pkg::*;
#(
  parameter int TABLE_SLOTS = 16,
  parameter int TIME_BITS   = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cmd_valid,
  input  wire cmd_t        cmd,
  output logic             cmd_pop,
  input  wire logic [15:0] retx_timeout,
  output logic             res_valid,
  output res_t             res,
  output logic             res_last,
  input  wire logic        res_ready
);

  localparam int IW = $clog2(TABLE_SLOTS);
  localparam int WB = (TIME_BITS > 16) ? TIME_BITS : 16;
  localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_SLOTS - 1);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_SRCH  = 7'b0000010,
    ST_EMIT  = 7'b0000100,
    ST_STORE = 7'b0001000,
    ST_REM   = 7'b0010000,
    ST_TICK  = 7'b0100000,
    ST_FIN   = 7'b1000000
  } state_t;

  // Slot storage
  logic [TIME_BITS-1:0] tm_r [TABLE_SLOTS];
  logic [3:0]           pk_r [TABLE_SLOTS];
  logic                 kd_r [TABLE_SLOTS];
  logic [2:0]           if_r [TABLE_SLOTS];
  logic [TABLE_SLOTS-1:0] busy_r, busy_nxt;

  state_t               state_r, state_nxt;
  ret_t                 ret_r, ret_nxt;
  logic [IW-1:0]        sidx_r, sidx_nxt, tidx_r, tidx_nxt;
  logic                 srch_info_r, srch_info_nxt;
  logic                 best_v_r, best_v_nxt;
  logic [IW-1:0]        best_idx_r, best_idx_nxt;
  logic [TIME_BITS-1:0] best_t_r, best_t_nxt;
  logic [3:0]           best_pkt_r, best_pkt_nxt;
  logic [2:0]           best_info_r, best_info_nxt;
  logic [3:0]           pkt_r, pkt_nxt;
  logic                 kind_r, kind_nxt;
  logic [2:0]           info_r, info_nxt;
  logic [TIME_BITS-1:0] t_r, t_nxt;
  logic                 hold_v_r, hold_v_nxt;
  res_t                 hold_r, hold_nxt;

  logic [TIME_BITS-1:0] dt_t, dly_t, rd_tm, tdec;
  logic [WB-1:0]        dt_ext, dly_ext;
  logic [IW-1:0]        rd_idx;
  logic [3:0]           rd_pk;
  logic                 rd_kd, rd_busy;
  logic [2:0]           rd_if;
  logic                 cand, can_put, produce;
  res_t                 new_res;
  logic                 wr_en, wr_all;
  logic [IW-1:0]        wr_idx;
  logic [TIME_BITS-1:0] wr_time;
  logic                 free_found;
  logic [IW-1:0]        free_idx;

  assign dt_ext  = WB'(retx_timeout);
  assign dt_t    = dt_ext[TIME_BITS-1:0];
  assign dly_ext = WB'(cmd.delay);
  assign dly_t   = dly_ext[TIME_BITS-1:0];

  // Single read address: tick walk or search/remove walk
  assign rd_idx  = (state_r == ST_TICK) ? tidx_r : sidx_r;
  assign rd_tm   = tm_r[rd_idx];
  assign rd_pk   = pk_r[rd_idx];
  assign rd_kd   = kd_r[rd_idx];
  assign rd_if   = if_r[rd_idx];
  assign rd_busy = busy_r[rd_idx];
  assign tdec    = (rd_tm == '0) ? '0 : rd_tm - 1'b1;

  // Search candidate: busy, right kind, time above zero, strictly smaller
  assign cand = rd_busy && (rd_kd == srch_info_r) && (rd_tm != '0) &&
                (!best_v_r || (rd_tm < best_t_r));

  assign can_put = !hold_v_r || res_ready;

  // Lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = TABLE_SLOTS - 1; i >= 0; i--) begin
      if (!busy_r[i]) begin
        free_found = 1'b1;
        free_idx   = IW'(i);
      end
    end
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    ret_nxt       = ret_r;
    sidx_nxt      = sidx_r;
    tidx_nxt      = tidx_r;
    srch_info_nxt = srch_info_r;
    best_v_nxt    = best_v_r;
    best_idx_nxt  = best_idx_r;
    best_t_nxt    = best_t_r;
    best_pkt_nxt  = best_pkt_r;
    best_info_nxt = best_info_r;
    pkt_nxt       = pkt_r;
    kind_nxt      = kind_r;
    info_nxt      = info_r;
    t_nxt         = t_r;
    busy_nxt      = busy_r;
    cmd_pop       = 1'b0;
    produce       = 1'b0;
    new_res       = '0;
    res_last      = 1'b0;
    wr_en         = 1'b0;
    wr_all        = 1'b0;
    wr_idx        = rd_idx;
    wr_time       = '0;

    case (state_r)
      ST_IDLE: begin
        if (cmd_valid) begin
          cmd_pop       = 1'b1;
          pkt_nxt       = cmd.packet;
          kind_nxt      = cmd.kind;
          info_nxt      = cmd.info;
          t_nxt         = dly_t;
          sidx_nxt      = '0;
          tidx_nxt      = '0;
          best_v_nxt    = 1'b0;
          case (cmd.op)
            OP_ADD: begin
              if (cmd.send_now) begin
                t_nxt         = dt_t;
                srch_info_nxt = 1'b1;
                ret_nxt       = RET_STORE;
                state_nxt     = ST_SRCH;
              end else begin
                state_nxt = ST_STORE;
              end
            end
            OP_REMOVE: state_nxt = ST_REM;
            OP_TICK:   state_nxt = ST_TICK;
            default: begin
              srch_info_nxt = 1'b0;
              ret_nxt       = RET_FIN;
              state_nxt     = ST_SRCH;
            end
          endcase
        end
      end

      ST_SRCH: begin
        if (cand) begin
          best_v_nxt    = 1'b1;
          best_idx_nxt  = sidx_r;
          best_t_nxt    = rd_tm;
          best_pkt_nxt  = rd_pk;
          best_info_nxt = rd_if;
        end
        if (sidx_r == LAST_IDX) begin
          if (srch_info_r) begin
            state_nxt = ST_EMIT;
          end else if (best_v_nxt) begin
            // soonest data entry: re-arm it, then look for a piggyback
            wr_en         = 1'b1;
            wr_idx        = best_idx_nxt;
            wr_time       = dt_t;
            pkt_nxt       = best_pkt_nxt;
            srch_info_nxt = 1'b1;
            sidx_nxt      = '0;
            best_v_nxt    = 1'b0;
          end else begin
            state_nxt = ST_FIN;
          end
        end else begin
          sidx_nxt = sidx_r + 1'b1;
        end
      end

      ST_EMIT: begin
        if (can_put) begin
          produce              = 1'b1;
          new_res.send_kind    = KIND_DATA;
          new_res.send_packet  = pkt_r;
          new_res.piggy_valid  = best_v_r;
          new_res.piggy_info   = best_v_r ? best_info_r : 3'd0;
          new_res.piggy_packet = best_v_r ? best_pkt_r : 4'd0;
          if (best_v_r) begin
            busy_nxt[best_idx_r] = 1'b0;
          end
          case (ret_r)
            RET_STORE: state_nxt = ST_STORE;
            RET_TICK: begin
              if (tidx_r == LAST_IDX) begin
                state_nxt = ST_FIN;
              end else begin
                tidx_nxt  = tidx_r + 1'b1;
                state_nxt = ST_TICK;
              end
            end
            default: state_nxt = ST_FIN;
          endcase
        end
      end

      ST_STORE: begin
        if (free_found) begin
          wr_en            = 1'b1;
          wr_all           = 1'b1;
          wr_idx           = free_idx;
          wr_time          = t_r;
          busy_nxt[free_idx] = 1'b1;
        end
        state_nxt = ST_FIN;
      end

      ST_REM: begin
        if (rd_busy && (rd_pk == pkt_r) && (rd_kd == kind_r)) begin
          busy_nxt[sidx_r] = 1'b0;
        end
        if (sidx_r == LAST_IDX) begin
          state_nxt = ST_FIN;
        end else begin
          sidx_nxt = sidx_r + 1'b1;
        end
      end

      ST_TICK: begin
        if (!rd_busy || (tdec != '0)) begin
          if (rd_busy) begin
            wr_en   = 1'b1;
            wr_time = tdec;
          end
          if (tidx_r == LAST_IDX) begin
            state_nxt = ST_FIN;
          end else begin
            tidx_nxt = tidx_r + 1'b1;
          end
        end else if (rd_kd == KIND_DATA) begin
          // expired data entry: re-arm and resend with piggyback
          wr_en         = 1'b1;
          wr_time       = dt_t;
          pkt_nxt       = rd_pk;
          srch_info_nxt = 1'b1;
          sidx_nxt      = '0;
          best_v_nxt    = 1'b0;
          ret_nxt       = RET_TICK;
          state_nxt     = ST_SRCH;
        end else if (can_put) begin
          // expired info entry: send and free
          produce             = 1'b1;
          new_res.send_kind   = KIND_INFO;
          new_res.send_packet = rd_pk;
          new_res.send_info   = rd_if;
          busy_nxt[tidx_r]    = 1'b0;
          if (tidx_r == LAST_IDX) begin
            state_nxt = ST_FIN;
          end else begin
            tidx_nxt = tidx_r + 1'b1;
          end
        end
      end

      ST_FIN: begin
        res_last = 1'b1;
        if (!hold_v_r || res_ready) begin
          state_nxt = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // The newest send is held in a register so the final one can carry last
  assign res_valid = hold_v_r && (produce || ((state_r == ST_FIN) && res_ready));
  assign res       = hold_r;

  always_comb begin
    hold_v_nxt = hold_v_r;
    hold_nxt   = hold_r;
    if (produce) begin
      hold_v_nxt = 1'b1;
      hold_nxt   = new_res;
    end else if ((state_r == ST_FIN) && res_ready) begin
      hold_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      busy_r   <= '0;
      hold_v_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      busy_r   <= busy_nxt;
      hold_v_r <= hold_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ret_r       <= ret_nxt;
    sidx_r      <= sidx_nxt;
    tidx_r      <= tidx_nxt;
    srch_info_r <= srch_info_nxt;
    best_v_r    <= best_v_nxt;
    best_idx_r  <= best_idx_nxt;
    best_t_r    <= best_t_nxt;
    best_pkt_r  <= best_pkt_nxt;
    best_info_r <= best_info_nxt;
    pkt_r       <= pkt_nxt;
    kind_r      <= kind_nxt;
    info_r      <= info_nxt;
    t_r         <= t_nxt;
    hold_r      <= hold_nxt;
  end

  // Slot writes: one port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      tm_r[wr_idx] <= wr_time;
    end
    if (wr_all) begin
      pk_r[wr_idx] <= pkt_r;
      kd_r[wr_idx] <= kind_r;
      if_r[wr_idx] <= info_r;
    end
  end

  // A chosen piggyback entry is still a busy info slot when it is sent
  a_piggy_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) && best_v_r |-> busy_r[best_idx_r] &&
      (kd_r[best_idx_r] == KIND_INFO))
    else $error("piggyback slot not a busy info entry");

  // Nothing is left held back once a command has finished
  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !hold_v_r)
    else $error("result pending in idle");

  // A result leaves the back end only when a downstream slot takes it
  a_push_ready: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> res_ready)
    else $error("result pushed without ready");

endmodule

`default_nettype wire
